// ===== hw/rtl/rds_pkg.sv =====
// Shared types, constants and helpers for the raster diffusion stencil block.
package rds_pkg;

  // Fixed field widths and defaults
  localparam int unsigned SAMPLE_W        = 32;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam int unsigned ROWS_W          = 16;
  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned COLS_RESET      = 1024;
  localparam logic [15:0] ROWS_RESET      = 16'd1024;
  localparam logic [15:0] FACTOR_RESET    = 16'd6554;
  localparam logic        MOORE_RESET     = 1'b1;

  // 1/sqrt2 in Q0.16
  localparam logic [15:0] DIAG_WEIGHT = 16'd46341;
  localparam int unsigned DIAG_STEPS  = 4;
  localparam int unsigned STEP_W      = 3;

  // Difference, accumulator and product widths
  localparam int unsigned DIFF_W  = SAMPLE_W + 1;
  localparam int unsigned ACC_W   = SAMPLE_W + 6;
  localparam int unsigned DPROD_W = DIFF_W + 17;
  localparam int unsigned SPROD_W = ACC_W + 17;
  localparam int unsigned SUM_W   = SAMPLE_W + 8;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_FACTOR  = 2'd2,
    CFG_MOORE   = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_ORTHO,
    ST_DIAG,
    ST_SCALE,
    ST_SAT
  } ctrl_state_e;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] elevation;
    logic                       no_data;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] new_elevation;
    logic                       out_no_data;
    logic                       frame_end;
  } out_word_t;

  typedef struct packed {
    logic                       nd;
    logic signed [SAMPLE_W-1:0] z;
  } cell_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              pass;
    logic              ortho;
    logic              diag;
    logic [STEP_W-1:0] diag_k;
    logic              scale;
    logic              emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ignore;
    logic emit_needed;
    logic out_free;
  } sts_t;

  // Masked neighbor-minus-center difference
  function automatic logic signed [DIFF_W-1:0] nb_diff(cell_t n, logic signed [SAMPLE_W-1:0] z,
                                                      logic en);
    logic signed [DIFF_W-1:0] d;
    d = '0;
    if (en && !n.nd) begin
      d = {n.z[SAMPLE_W-1], n.z} - {z[SAMPLE_W-1], z};
    end
    return d;
  endfunction

  function automatic logic signed [ACC_W-1:0] diff_ext(logic signed [DIFF_W-1:0] d);
    return {{(ACC_W-DIFF_W){d[DIFF_W-1]}}, d};
  endfunction

endpackage

// ===== hw/rtl/raster_diffusion_stencil_step.sv =====
// Top level: 3x3 explicit diffusion stencil over a streamed raster.
// A word is taken only once the last is through. A word that yields no result
// takes only pass; one that does takes pass, sum, five diagonal steps, scale
// and saturate, and saturate waits while the output is stalled.
// Reset clears the frame position, the window (to no-data) and sets register
// defaults; line stores start undefined and unwritten entries are never used.
module raster_diffusion_stencil_step #(
  parameter int unsigned MAX_COLUMNS = rds_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rds_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rds_pkg::out_word_t              out_word_o,
  input  logic                            cfg_we_i,
  input  logic [rds_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [rds_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rds_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hw/rtl/rds_datapath.sv =====
// Datapath: frame position, line stores, 3x3 window, stencil arithmetic, output register.
module rds_datapath #(
  parameter int unsigned MAX_COLUMNS = rds_pkg::MAX_COLUMNS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rds_pkg::in_word_t             in_word_i,
  input  rds_pkg::cmd_t                 cmd_i,
  output rds_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [rds_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [rds_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rds_pkg::out_word_t            out_word_o
);
  import rds_pkg::*;

  localparam int unsigned AW = $clog2(MAX_COLUMNS);
  localparam int unsigned CW = $clog2(MAX_COLUMNS + 2);
  localparam int unsigned COLS_RST_I = (MAX_COLUMNS < COLS_RESET) ? MAX_COLUMNS : COLS_RESET;
  localparam logic [CW-1:0] COLS_RST = CW'(COLS_RST_I);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef struct packed {
    logic emit;
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } flags_t;

  // Configuration and position registers
  logic [CW-1:0]     cols_q, cols_d;
  logic [ROWS_W-1:0] rows_q, rows_d;
  logic [15:0]       factor_q, factor_d;
  logic              moore_q, moore_d;
  logic [AW-1:0]     col_q, col_d;
  logic [ROWS_W-1:0] row_q, row_d;
  logic [CW-1:0]     pend_q, pend_d;

  // Per-item registers
  flags_t        flags_q, flags_d;
  cell_t         bot_q;
  logic [AW-1:0] addr_q, addr_d;
  cell_t         up_rd_q, mid_rd_q;

  // Line stores
  cell_t up_mem_q  [MAX_COLUMNS];
  cell_t mid_mem_q [MAX_COLUMNS];

  cell_t win_q [3][3];

  // Arithmetic registers
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [DPROD_W-1:0] dprod_q;
  logic signed [SPROD_W-1:0] sprod_q;

  logic      out_valid_q;
  out_word_t out_word_q;

  // Accept decision
  logic              pend_nz, is_drain, ignore;
  logic [AW-1:0]     c_cur;
  logic [ROWS_W-1:0] r_cur;
  logic [CW-1:0]     t_pos;
  int unsigned       cfg_cols;

  always_comb begin
    pend_nz  = (pend_q != '0);
    is_drain = in_word_i.func;
    ignore   = is_drain && !pend_nz;
    c_cur    = pend_nz ? '0 : col_q;
    r_cur    = pend_nz ? '0 : row_q;
    t_pos    = cols_q + CW'(1) - pend_q;
    flags_d  = '0;
    addr_d   = c_cur;
    col_d    = col_q;
    row_d    = row_q;
    pend_d   = pend_q;
    if (!is_drain) begin
      flags_d.bot = 1'b1;
      if (c_cur != '0) begin
        flags_d.emit  = (r_cur >= ROWS_W'(1));
        flags_d.top   = (r_cur >= ROWS_W'(2));
        flags_d.left  = (c_cur >= AW'(2));
        flags_d.right = 1'b1;
      end else begin
        flags_d.emit  = (r_cur >= ROWS_W'(2));
        flags_d.top   = (r_cur >= ROWS_W'(3));
        flags_d.left  = (cols_q >= CW'(2));
      end
      col_d  = c_cur;
      row_d  = r_cur;
      pend_d = '0;
      if ((CW'(c_cur) + CW'(1)) >= cols_q) begin
        col_d = '0;
        if (({1'b0, r_cur} + 17'd1) >= {1'b0, rows_q}) begin
          row_d  = '0;
          pend_d = cols_q + CW'(1);
        end else begin
          row_d = r_cur + ROWS_W'(1);
        end
      end else begin
        col_d = c_cur + AW'(1);
      end
    end else begin
      addr_d = (t_pos < cols_q) ? t_pos[AW-1:0] : '0;
      pend_d = pend_q - CW'(1);
      if (t_pos == '0) begin
        flags_d.emit = (rows_q >= ROWS_W'(2));
        flags_d.top  = (rows_q >= ROWS_W'(3));
        flags_d.bot  = 1'b1;
        flags_d.left = (cols_q >= CW'(2));
      end else if (t_pos < cols_q) begin
        flags_d.emit  = 1'b1;
        flags_d.top   = (rows_q >= ROWS_W'(2));
        flags_d.left  = (t_pos >= CW'(2));
        flags_d.right = 1'b1;
      end else begin
        flags_d.emit = 1'b1;
        flags_d.top  = (rows_q >= ROWS_W'(2));
        flags_d.left = (cols_q >= CW'(2));
        flags_d.last = 1'b1;
      end
    end
  end

  // Configuration writes
  always_comb begin
    cols_d   = cols_q;
    rows_d   = rows_q;
    factor_d = factor_q;
    moore_d  = moore_q;
    cfg_cols = 32'(cfg_data_i[10:0]);
    if (cfg_cols < 1) begin
      cfg_cols = 1;
    end
    if (cfg_cols > MAX_COLUMNS) begin
      cfg_cols = MAX_COLUMNS;
    end
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_COLUMNS: cols_d   = CW'(cfg_cols);
        CFG_ROWS:    rows_d   = (cfg_data_i == '0) ? ROWS_W'(1) : cfg_data_i;
        CFG_FACTOR:  factor_d = cfg_data_i;
        CFG_MOORE:   moore_d  = cfg_data_i[0];
        default:     cols_d   = cols_q;
      endcase
    end
  end

  logic cfg_clear;
  assign cfg_clear = cfg_we_i && ((cfg_index_e'(cfg_index_i) == CFG_COLUMNS) ||
                                  (cfg_index_e'(cfg_index_i) == CFG_ROWS));

  // Config and position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= COLS_RST;
      rows_q   <= ROWS_RESET;
      factor_q <= FACTOR_RESET;
      moore_q  <= MOORE_RESET;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
    end else begin
      cols_q   <= cols_d;
      rows_q   <= rows_d;
      factor_q <= factor_d;
      moore_q  <= moore_d;
      if (cfg_clear) begin
        col_q  <= '0;
        row_q  <= '0;
        pend_q <= '0;
      end else if (cmd_i.load && !ignore) begin
        col_q  <= col_d;
        row_q  <= row_d;
        pend_q <= pend_d;
      end
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !ignore) begin
      flags_q <= flags_d;
      addr_q  <= addr_d;
      if (is_drain) begin
        bot_q.nd <= 1'b1;
        bot_q.z  <= '0;
      end else begin
        bot_q.nd <= in_word_i.no_data;
        bot_q.z  <= in_word_i.elevation;
      end
    end
  end

  // Line stores: read on accept, write back on pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !ignore) begin
      up_rd_q  <= up_mem_q[addr_d];
      mid_rd_q <= mid_mem_q[addr_d];
    end
    if (cmd_i.pass) begin
      up_mem_q[addr_q]  <= mid_rd_q;
      mid_mem_q[addr_q] <= bot_q;
    end
  end

  // Window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[r][k] <= '{nd: 1'b1, z: '0};
        end
      end
    end else if (cmd_i.pass) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up_rd_q;
      win_q[1][2] <= mid_rd_q;
      win_q[2][2] <= bot_q;
    end
  end

  // Stencil arithmetic
  logic signed [SAMPLE_W-1:0] zc;
  logic signed [ACC_W-1:0]    ortho_sum;
  logic signed [DIFF_W-1:0]   diag_d;
  logic signed [DPROD_W-1:0]  dprod_d;
  logic signed [SPROD_W-1:0]  sprod_d;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic signed [16:0]         diag_w17, factor17;

  assign zc       = win_q[1][1].z;
  assign diag_w17 = $signed({1'b0, DIAG_WEIGHT});
  assign factor17 = $signed({1'b0, factor_q});

  always_comb begin
    ortho_sum = diff_ext(nb_diff(win_q[0][1], zc, flags_q.top))
              + diff_ext(nb_diff(win_q[2][1], zc, flags_q.bot))
              + diff_ext(nb_diff(win_q[1][0], zc, flags_q.left))
              + diff_ext(nb_diff(win_q[1][2], zc, flags_q.right));
    case (cmd_i.diag_k)
      3'd0:    diag_d = nb_diff(win_q[0][0], zc, moore_q && flags_q.top && flags_q.left);
      3'd1:    diag_d = nb_diff(win_q[0][2], zc, moore_q && flags_q.top && flags_q.right);
      3'd2:    diag_d = nb_diff(win_q[2][0], zc, moore_q && flags_q.bot && flags_q.left);
      3'd3:    diag_d = nb_diff(win_q[2][2], zc, moore_q && flags_q.bot && flags_q.right);
      default: diag_d = '0;
    endcase
    dprod_d = diag_d * diag_w17;
    sprod_d = acc_q * factor17;
    sum     = {{(SUM_W-SAMPLE_W){zc[SAMPLE_W-1]}}, zc}
            + {sprod_q[SPROD_W-1], sprod_q[SPROD_W-1:16]};
    if (sum > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_W-1:0];
    end else if (sum < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat_val = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ortho) begin
      acc_q <= ortho_sum;
    end else if (cmd_i.diag && (cmd_i.diag_k != '0)) begin
      acc_q <= acc_q + {{(ACC_W-(DPROD_W-16)){dprod_q[DPROD_W-1]}}, dprod_q[DPROD_W-1:16]};
    end
    if (cmd_i.diag && (cmd_i.diag_k < STEP_W'(DIAG_STEPS))) begin
      dprod_q <= dprod_d;
    end
    if (cmd_i.scale) begin
      sprod_q <= sprod_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q.new_elevation <= win_q[1][1].nd ? zc : sat_val;
      out_word_q.out_no_data   <= win_q[1][1].nd;
      out_word_q.frame_end     <= flags_q.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_word_o        = out_word_q;
  assign sts_o.ignore      = ignore;
  assign sts_o.emit_needed = flags_q.emit;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

// ===== hw/rtl/rds_ctrl.sv =====
// Controller: pass per word; sum, diagonal, scale and saturate if it emits.
module rds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rds_pkg::sts_t sts_i,
  output rds_pkg::cmd_t cmd_o
);
  import rds_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] k_q, k_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    cmd_o        = '0;
    cmd_o.diag_k = k_q;
    in_stall_o   = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.ignore) begin
            state_d = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        cmd_o.pass = 1'b1;
        state_d    = sts_i.emit_needed ? ST_ORTHO : ST_IDLE;
      end
      ST_ORTHO: begin
        cmd_o.ortho = 1'b1;
        k_d         = '0;
        state_d     = ST_DIAG;
      end
      ST_DIAG: begin
        cmd_o.diag = 1'b1;
        if (k_q == STEP_W'(DIAG_STEPS)) begin
          state_d = ST_SCALE;
        end else begin
          k_d = k_q + STEP_W'(1);
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_SAT;
      end
      ST_SAT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
